@@ rtl/core/mtc_pkg.sv @@
// Shared types and constants for the multi-terminal text console.
package mtc_pkg;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_SWITCH = 2'd1,
    CMD_COLOR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_TAB       = 8'd9;
  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_SPACE     = 8'd32;

  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_CELL   = {RESET_COLOR, CH_SPACE};

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

endpackage

@@ rtl/core/multi_terminal_text_console.sv @@
// Top level of the multi-terminal text console: command sequencer around the cell memory.
//
// Commands arrive as beats on s_axis; every command gives exactly one result beat on
// m_axis carrying the cell word read (zero unless a read), the active screen's cursor
// and the active screen index after the command.
// A command passes from accept through an execute state to the result state; a read
// inside the screen adds a read state, a printable character a write state, and a tab
// one write per space written. The result beat turns valid as the result state ends.
// A scroll copies the screen one cell per cycle through the memory's read and write
// ports and blanks the bottom row; it follows a newline on the bottom row or a character
// written past the bottom, which is then written on the fresh bottom row.
// One command is worked at a time; the memory's single write port sets the pace.
// After reset all SCREENS*ROWS*COLUMNS cells (8000 by default) are blanked by a sweep,
// during which s_axis_tready stays low; cursors go to the top left, colors to grey on
// black and screen 0 is active.
// A finished result waits in the output register while m_axis_tready is low; the next
// command is still accepted and worked, and its result holds until the register frees.
module multi_terminal_text_console_core #(
  parameter int unsigned SCREENS  = 4,
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 25,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[1:0], char_code[9:2], terminal_index[12:10], fg_color[16:13],
  // bg_color[20:17], cell_row[25:21], cell_col[32:26], zero[39:33]
  input  logic [mtc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cell_data[15:0], cursor_row[20:16], cursor_col[27:21], active_screen[30:28], zero[31]
  output logic [mtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned SCR_W  = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLUMNS + 1);
  localparam int unsigned CELLS  = ROWS * COLUMNS;
  localparam int unsigned DEPTH  = SCREENS * CELLS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned KW     = $clog2(CELLS);
  localparam int unsigned COPY_N = (ROWS - 1) * COLUMNS;
  localparam int unsigned PAD_W  = $clog2(TAB_STOP + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_SCROLL,
    S_DRAIN,
    S_READ,
    S_DONE
  } state_e;

  state_e              state_q;
  mtc_pkg::cmd_e       cmd_q;
  logic [7:0]          ch_q;
  logic [2:0]          idx_q;
  logic [3:0]          fg_q;
  logic [3:0]          bg_q;
  logic [4:0]          rrow_q;
  logic [6:0]          rcol_q;

  logic [ROW_W-1:0]    row_q   [SCREENS];
  logic [COL_W-1:0]    col_q   [SCREENS];
  logic [7:0]          color_q [SCREENS];
  logic [SCR_W-1:0]    act_q;
  logic [AW-1:0]       base_q;

  logic [7:0]          wch_q;
  logic [PAD_W-1:0]    pad_q;
  logic [KW-1:0]       k_q;
  logic                ret_write_q;
  logic [15:0]         data_q;

  logic                wr_en_q;
  logic                wr_ram_q;
  logic [AW-1:0]       wr_addr_q;
  logic [15:0]         wr_data_q;

  logic                out_valid_q;
  logic [mtc_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  logic [7:0]          cur_color;
  logic                wrap;
  logic                need_scroll;
  logic [ROW_W-1:0]    put_row;
  logic [COL_W-1:0]    put_col;
  logic [AW-1:0]       put_addr;
  logic [AW-1:0]       rd_addr;
  logic                rd_in_range;
  logic [AW-1:0]       sc_dst;
  logic [AW-1:0]       sc_src;
  logic                sc_copy;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [15:0]         rdata;
  logic [15:0]         wdata;
  logic                ram_busy;
  logic [PAD_W-1:0]    tab_pad [2**COL_W];

  // Spaces a tab puts at each column; a pending wrap counts as column COLUMNS.
  for (genvar i = 0; i < 2**COL_W; i++) begin : g_tab
    assign tab_pad[i] = PAD_W'(TAB_STOP - (i % TAB_STOP));
  end

  assign cur_row   = row_q[act_q];
  assign cur_col   = col_q[act_q];
  assign cur_color = color_q[act_q];

  assign wrap        = (cur_col == COL_W'(COLUMNS));
  assign need_scroll = wrap && (cur_row == ROW_W'(ROWS - 1));
  assign put_row     = wrap ? cur_row + 1'b1 : cur_row;
  assign put_col     = wrap ? '0 : cur_col;
  assign put_addr    = base_q + AW'(put_row) * AW'(COLUMNS) + AW'(put_col);

  assign rd_in_range = ({1'b0, rrow_q} < 6'(ROWS)) && ({1'b0, rcol_q} < 8'(COLUMNS));
  assign rd_addr     = base_q + AW'(rrow_q) * AW'(COLUMNS) + AW'(rcol_q);

  assign sc_copy = (k_q < KW'(COPY_N));
  assign sc_dst  = base_q + AW'(k_q);
  assign sc_src  = sc_dst + AW'(COLUMNS);

  always_comb begin
    re    = 1'b0;
    raddr = rd_addr;
    if (state_q == S_SCROLL) begin
      re    = sc_copy;
      raddr = sc_src;
    end else if (state_q == S_EXEC && cmd_q == mtc_pkg::CMD_READ) begin
      re = rd_in_range;
    end
  end

  assign wdata = wr_ram_q ? rdata : wr_data_q;

  mtc_cell_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .busy_o  (ram_busy)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !ram_busy;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      base_q      <= '0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ret_write_q <= 1'b0;
      for (int i = 0; i < SCREENS; i++) begin
        row_q[i]   <= '0;
        col_q[i]   <= '0;
        color_q[i] <= mtc_pkg::RESET_COLOR;
      end
    end else begin
      wr_en_q <= ((state_q == S_WRITE) && !need_scroll) || (state_q == S_SCROLL);
      if (m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_q   <= mtc_pkg::cmd_e'(s_axis_tdata[1:0]);
            ch_q    <= s_axis_tdata[9:2];
            idx_q   <= s_axis_tdata[12:10];
            fg_q    <= s_axis_tdata[16:13];
            bg_q    <= s_axis_tdata[20:17];
            rrow_q  <= s_axis_tdata[25:21];
            rcol_q  <= s_axis_tdata[32:26];
            data_q  <= '0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q)
            mtc_pkg::CMD_PUT: begin
              priority if (ch_q == mtc_pkg::CH_NEWLINE) begin
                if (cur_row == ROW_W'(ROWS - 1)) begin
                  k_q         <= '0;
                  ret_write_q <= 1'b0;
                  state_q     <= S_SCROLL;
                end else begin
                  row_q[act_q] <= cur_row + 1'b1;
                  col_q[act_q] <= '0;
                  state_q      <= S_DONE;
                end
              end else if (ch_q == mtc_pkg::CH_RETURN) begin
                col_q[act_q] <= '0;
                state_q      <= S_DONE;
              end else if (ch_q == mtc_pkg::CH_BACKSPACE) begin
                if (cur_col == '0) begin
                  if (cur_row != '0) begin
                    row_q[act_q] <= cur_row - 1'b1;
                    col_q[act_q] <= COL_W'(COLUMNS - 1);
                  end
                end else begin
                  col_q[act_q] <= cur_col - 1'b1;
                end
                state_q <= S_DONE;
              end else if (ch_q == mtc_pkg::CH_TAB) begin
                wch_q   <= mtc_pkg::CH_SPACE;
                pad_q   <= tab_pad[cur_col];
                state_q <= S_WRITE;
              end else begin
                wch_q   <= ch_q;
                pad_q   <= PAD_W'(1);
                state_q <= S_WRITE;
              end
            end
            mtc_pkg::CMD_SWITCH: begin
              if (4'(idx_q) < 4'(SCREENS)) begin
                act_q  <= SCR_W'(idx_q);
                base_q <= AW'(idx_q) * AW'(CELLS);
              end
              state_q <= S_DONE;
            end
            mtc_pkg::CMD_COLOR: begin
              color_q[act_q] <= {bg_q, fg_q};
              state_q        <= S_DONE;
            end
            mtc_pkg::CMD_READ: begin
              state_q <= rd_in_range ? S_READ : S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_WRITE: begin
          if (need_scroll) begin
            k_q         <= '0;
            ret_write_q <= 1'b1;
            state_q     <= S_SCROLL;
          end else begin
            wr_ram_q     <= 1'b0;
            wr_addr_q    <= put_addr;
            wr_data_q    <= {cur_color, wch_q};
            row_q[act_q] <= put_row;
            col_q[act_q] <= put_col + 1'b1;
            pad_q        <= pad_q - 1'b1;
            if (pad_q == PAD_W'(1)) begin
              state_q <= S_DONE;
            end
          end
        end
        S_SCROLL: begin
          // Copy one cell up a row per cycle, then blank the bottom row.
          wr_ram_q  <= sc_copy;
          wr_addr_q <= sc_dst;
          wr_data_q <= {cur_color, mtc_pkg::CH_SPACE};
          k_q       <= k_q + 1'b1;
          if (k_q == KW'(CELLS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          row_q[act_q] <= ROW_W'(ROWS - 1);
          col_q[act_q] <= '0;
          state_q      <= ret_write_q ? S_WRITE : S_DONE;
        end
        S_READ: begin
          data_q  <= rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register frees.
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {1'b0, 3'(act_q), 7'(cur_col), 5'(cur_row), data_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/mtc_cell_ram.sv @@
// Cell memory with one write and one registered read port, blanked by a sweep after reset.
module mtc_cell_ram #(
  parameter  int unsigned DEPTH = 8000,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o,
  output logic          busy_o
);

  logic [15:0]   mem [DEPTH];
  logic [AW-1:0] clr_q;
  logic          busy_q;

  // Sweep every entry once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= mtc_pkg::RESET_CELL;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

  assign busy_o = busy_q;

endmodule
